// ===== rtl/core/bmr_pkg.sv =====
// Package: shared constants, types and helpers for the box mean block.
`timescale 1ns / 1ps
package bmr_pkg;
  localparam int MaxWidth   = 256;
  localparam int MaxHeight  = 256;
  localparam int MaxRadius  = 64;
  localparam int SampleBits = 16;
  localparam int XW   = $clog2(MaxWidth);
  localparam int YW   = $clog2(MaxHeight);
  localparam int CW   = (XW > YW) ? XW : YW;
  localparam int AW   = XW + YW;
  localparam int RW   = 7;
  localparam int DW   = 9;
  localparam int RSW  = 24;
  localparam int CSW  = 32;
  localparam int IDXW = 2;

  localparam logic [IDXW-1:0] RegRadius = 2'd0;
  localparam logic [IDXW-1:0] RegWidth  = 2'd1;
  localparam logic [IDXW-1:0] RegHeight = 2'd2;

  localparam logic KindLoad  = 1'b0;
  localparam logic KindDrain = 1'b1;

  // request classified by the front end
  typedef struct packed {
    logic                  kind;
    logic [SampleBits-1:0] sample;
  } req_t;

  typedef struct packed {
    logic [SampleBits-1:0] mean;
    logic                  last;
    logic                  status;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ROW_INIT, ST_ROW_PRE, ST_ROW_RD, ST_ROW_ACC, ST_ROW_WR,
    ST_COL_INIT, ST_COL_PRE, ST_COL_RD, ST_COL_ACC, ST_SUM_RD, ST_SUM_ACC,
    ST_DIV, ST_OUT
  } bstate_e;

  // one reflect-101 step of a folded index m over extent n, forward or back;
  // up: m grows as the coordinate grows. Returns {up, m}.
  function automatic logic [CW:0] walk(input logic [CW-1:0] m, input logic up,
                                       input logic fwd, input logic [DW-1:0] n);
    logic          rising;
    logic [CW-1:0] mn;
    rising = (up == fwd);
    mn     = m;
    if (n <= DW'(1)) begin
      mn = '0;
    end else if (rising) begin
      if (DW'(m) == n - DW'(1)) begin
        mn     = m - 1'b1;
        rising = 1'b0;
      end else begin
        mn = m + 1'b1;
      end
    end else if (m == '0) begin
      mn     = CW'(1);
      rising = 1'b1;
    end else begin
      mn = m - 1'b1;
    end
    return {rising == fwd, mn};
  endfunction
endpackage

// ===== rtl/core/box_mean_reflect101_top.sv =====
// Top level: box mean filter with reflect-101 borders.
`timescale 1ns / 1ps
// channel  | dir | fields
// s_axis   | in  | tdata[15:0]=sample, tuser=kind
// m_axis   | out | tdata[15:0]=mean, tlast=last, tuser=status
// cfg      | in  | cfg_idx_i=register index, cfg_data_i=value
// The last load starts a row pass, which visits every pixel of the frame.
// A drain at column 0 first runs a column pass over every column of the frame.
// Then each drain reads its column sum, runs the divider and registers the mean.
// A drain before the frame is loaded gets its status result right after it is popped.
// Reset clears the state, the load and drain positions and the result valid; stores are undefined until loaded.
// A waiting result holds back drains only; loads flow until the two-entry queue fills.
module box_mean_reflect101_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // sample
  input  logic        s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // mean
  output logic        m_axis_tlast,
  output logic        m_axis_tuser,   // status
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_idx_i,
  input  logic [8:0]  cfg_data_i
);
  import bmr_pkg::*;
  logic [RW-1:0] radius_q;
  logic [DW-1:0] width_q, height_q;
  logic restart, full, empty, pop;
  req_t req, head;
  rsp_t rsp;

  assign cfg_ready_o = 1'b1;
  assign restart = cfg_valid_i && (cfg_idx_i == RegRadius ||
                   cfg_idx_i == RegWidth || cfg_idx_i == RegHeight);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RW'(1); width_q <= DW'(256); height_q <= DW'(256);
    end else if (cfg_valid_i) begin
      case (cfg_idx_i)
        RegRadius: radius_q <= cfg_data_i[RW-1:0];
        RegWidth:  width_q  <= cfg_data_i;
        RegHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !full;
  assign req = '{kind: s_axis_tuser, sample: s_axis_tdata};

  bmr_fifo u_q (
    .clk_i, .rst_ni, .flush_i(restart), .push_i(s_axis_tvalid && !full),
    .push_data_i(req), .full_o(full), .pop_i(pop), .empty_o(empty),
    .pop_data_o(head));

  bmr_back u_back (
    .clk_i, .rst_ni, .restart_i(restart), .radius_i(radius_q),
    .width_i(width_q), .height_i(height_q), .req_valid_i(!empty),
    .req_i(head), .req_pop_o(pop), .rsp_valid_o(m_axis_tvalid),
    .rsp_o(rsp), .rsp_ready_i(m_axis_tready));

  assign m_axis_tdata = rsp.mean;
  assign m_axis_tlast = rsp.last;
  assign m_axis_tuser = rsp.status;

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty) else $error("pop on empty queue");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
  a_status_mean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0) else $error("bad status");
`endif
endmodule

// ===== rtl/core/bmr_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module bmr_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== rtl/core/bmr_fifo.sv =====
// Two-entry request queue between front and back.
`timescale 1ns / 1ps
module bmr_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           flush_i,
  input  logic           push_i,
  input  bmr_pkg::req_t  push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output bmr_pkg::req_t  pop_data_o
);
  import bmr_pkg::*;
  req_t       slot_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  assign full_o     = cnt_q == 2'd2;
  assign empty_o    = cnt_q == 2'd0;
  assign pop_data_o = slot_q[rp_q];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else if (flush_i) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end
  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wp_q] <= push_data_i;
  end
endmodule

// ===== rtl/core/bmr_back.sv =====
// Back end: frame store, row pass, column pass, divider and result register.
`timescale 1ns / 1ps
module bmr_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     restart_i,
  input  logic [bmr_pkg::RW-1:0]   radius_i,
  input  logic [bmr_pkg::DW-1:0]   width_i,
  input  logic [bmr_pkg::DW-1:0]   height_i,
  input  logic                     req_valid_i,
  input  bmr_pkg::req_t            req_i,
  output logic                     req_pop_o,
  output logic                     rsp_valid_o,
  output bmr_pkg::rsp_t            rsp_o,
  input  logic                     rsp_ready_i
);
  import bmr_pkg::*;

  bstate_e st_q, st_d;
  logic [RW-1:0] r_eff;
  logic [DW-1:0] w_eff, h_eff;
  logic [AW:0]   total;
  logic [AW:0]   lpos_q, lpos_d, dpos_q, dpos_d;
  logic [XW-1:0] lx_q, lx_d, dx_q, dx_d, x_q, x_d;
  logic [YW-1:0] ly_q, ly_d, dy_q, dy_d, y_q, y_d;
  logic [CW-1:0] m_q, m_d;
  logic          up_q, up_d;
  logic [RW-1:0] cnt_q, cnt_d;
  logic [RW:0]   tcnt_q, tcnt_d;
  logic [CSW-1:0] acc_q, acc_d;
  logic [CSW-1:0] num_q, num_d;
  logic [SampleBits-1:0] quo_q, quo_d;
  logic [4:0]    dcnt_q, dcnt_d;
  logic [CSW-1:0] rem_q, rem_d;
  logic [14:0]   div_q;
  logic          busy;
  rsp_t          rsp_q, rsp_d;
  logic          rv_q, rv_d;
  logic          loading, load_done, frame_end;
  logic          lx_end, dx_end, x_end, y_end;
  logic [DW-1:0] walk_n;
  logic [CW:0]   back_step, fwd_step;

  // memories
  logic fs_we, rs_we, cs_we;
  logic [AW-1:0] fs_waddr, fs_raddr, rs_waddr, rs_raddr;
  logic [SampleBits-1:0] fs_rdata;
  logic [RSW-1:0] rs_rdata;
  logic [CSW-1:0] cs_rdata, cs_wdata;
  logic [14:0]   nsq;
  logic [7:0]    n2;

  assign r_eff = (radius_i == '0) ? RW'(1) :
                 (radius_i > RW'(MaxRadius)) ? RW'(MaxRadius) : radius_i;
  assign w_eff = (width_i == '0) ? DW'(1) :
                 (width_i > DW'(MaxWidth)) ? DW'(MaxWidth) : width_i;
  assign h_eff = (height_i == '0) ? DW'(1) :
                 (height_i > DW'(MaxHeight)) ? DW'(MaxHeight) : height_i;
  assign total = (AW+1)'(w_eff) * (AW+1)'(h_eff);
  assign loading   = lpos_q < total;
  assign load_done = (lpos_q + (AW+1)'(1)) == total;
  assign frame_end = (dpos_q + (AW+1)'(1)) >= total;
  assign lx_end = DW'(lx_q) == w_eff - DW'(1);
  assign dx_end = DW'(dx_q) == w_eff - DW'(1);
  assign x_end  = DW'(x_q) == w_eff - DW'(1);
  assign y_end  = DW'(y_q) == h_eff - DW'(1);

  // reflect walker: rows fold over the width, columns over the height
  assign walk_n    = (st_q inside {ST_COL_PRE, ST_COL_ACC}) ? h_eff : w_eff;
  assign back_step = walk(m_q, up_q, 1'b0, walk_n);
  assign fwd_step  = walk(m_q, up_q, 1'b1, walk_n);

  assign busy = st_q != ST_IDLE;
  // a waiting result only holds back drains
  assign req_pop_o = (st_q == ST_IDLE) && req_valid_i &&
                     (req_i.kind == KindLoad || !rv_q);

  assign fs_we    = req_pop_o && req_i.kind == KindLoad && loading;
  assign fs_waddr = {ly_q, lx_q};
  assign fs_raddr = {y_q, XW'(m_q)};
  assign rs_we    = st_q == ST_ROW_WR;
  assign rs_waddr = {y_q, x_q};
  assign rs_raddr = {YW'(m_q), x_q};
  assign cs_we    = (st_q == ST_COL_ACC) && (tcnt_q == '0);
  assign cs_wdata = acc_q + CSW'(rs_rdata);

  bmr_ram #(.Width(SampleBits), .Depth(MaxWidth*MaxHeight)) u_frame (
    .clk_i, .we_i(fs_we), .waddr_i(fs_waddr), .wdata_i(req_i.sample),
    .raddr_i(fs_raddr), .rdata_o(fs_rdata));
  bmr_ram #(.Width(RSW), .Depth(MaxWidth*MaxHeight)) u_rows (
    .clk_i, .we_i(rs_we), .waddr_i(rs_waddr), .wdata_i(acc_q[RSW-1:0]),
    .raddr_i(rs_raddr), .rdata_o(rs_rdata));
  bmr_ram #(.Width(CSW), .Depth(MaxWidth)) u_cols (
    .clk_i, .we_i(cs_we), .waddr_i(x_q), .wdata_i(cs_wdata),
    .raddr_i(x_q), .rdata_o(cs_rdata));

  assign n2  = {r_eff, 1'b1};
  assign nsq = 15'(n2) * 15'(n2);

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (req_pop_o) begin
          if (req_i.kind == KindLoad) begin
            if (loading && load_done) st_d = ST_ROW_INIT;
          end else if (!loading) begin
            st_d = (dx_q == '0) ? ST_COL_INIT : ST_SUM_RD;
          end
        end
      end
      ST_ROW_INIT: st_d = ST_ROW_PRE;
      ST_ROW_PRE: begin
        if (cnt_q == RW'(1)) st_d = ST_ROW_RD;
      end
      ST_ROW_RD:  st_d = ST_ROW_ACC;
      ST_ROW_ACC: st_d = (tcnt_q == '0) ? ST_ROW_WR : ST_ROW_RD;
      ST_ROW_WR:  st_d = (x_end && y_end) ? ST_IDLE : ST_ROW_INIT;
      ST_COL_INIT: st_d = ST_COL_PRE;
      ST_COL_PRE: begin
        if (cnt_q == RW'(1)) st_d = ST_COL_RD;
      end
      ST_COL_RD: st_d = ST_COL_ACC;
      ST_COL_ACC: begin
        if (tcnt_q != '0) st_d = ST_COL_RD;
        else st_d = x_end ? ST_SUM_RD : ST_COL_INIT;
      end
      ST_SUM_RD:  st_d = ST_SUM_ACC;
      ST_SUM_ACC: st_d = ST_DIV;
      ST_DIV: begin
        if (dcnt_q == 5'd1) st_d = ST_OUT;
      end
      ST_OUT:  st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    lpos_d = lpos_q; dpos_d = dpos_q;
    lx_d = lx_q; ly_d = ly_q; dx_d = dx_q; dy_d = dy_q;
    x_d = x_q; y_d = y_q; m_d = m_q; up_d = up_q; cnt_d = cnt_q; tcnt_d = tcnt_q;
    acc_d = acc_q; num_d = num_q; quo_d = quo_q; dcnt_d = dcnt_q; rem_d = rem_q;
    rsp_d = rsp_q; rv_d = rv_q;
    if (rv_q && rsp_ready_i) rv_d = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (req_pop_o) begin
          if (req_i.kind == KindLoad) begin
            if (loading) begin
              lpos_d = lpos_q + (AW+1)'(1);
              if (lx_end) begin
                lx_d = '0; ly_d = ly_q + 1'b1;
              end else lx_d = lx_q + 1'b1;
              // row pass starts at the top left
              x_d = '0; y_d = '0;
            end
          end else if (loading) begin
            rsp_d = '{mean: '0, last: 1'b0, status: 1'b1}; rv_d = 1'b1;
          end else begin
            x_d = dx_q; y_d = dy_q;
          end
        end
      end
      ST_ROW_INIT: begin
        m_d = CW'(x_q); up_d = 1'b1; cnt_d = r_eff; tcnt_d = {r_eff, 1'b0};
        acc_d = '0;
      end
      ST_COL_INIT: begin
        m_d = CW'(y_q); up_d = 1'b1; cnt_d = r_eff; tcnt_d = {r_eff, 1'b0};
        acc_d = '0;
      end
      ST_ROW_PRE, ST_COL_PRE: begin
        // walk back r steps to the window start
        {up_d, m_d} = back_step;
        cnt_d = cnt_q - 1'b1;
      end
      ST_ROW_ACC: begin
        acc_d = acc_q + CSW'(fs_rdata);
        if (tcnt_q != '0) begin
          tcnt_d = tcnt_q - 1'b1; {up_d, m_d} = fwd_step;
        end
      end
      ST_ROW_WR: begin
        if (x_end) begin
          x_d = '0; y_d = y_q + 1'b1;
        end else x_d = x_q + 1'b1;
      end
      ST_COL_ACC: begin
        acc_d = acc_q + CSW'(rs_rdata);
        if (tcnt_q != '0) begin
          tcnt_d = tcnt_q - 1'b1; {up_d, m_d} = fwd_step;
        end else if (x_end) begin
          x_d = dx_q;
        end else x_d = x_q + 1'b1;
      end
      ST_SUM_ACC: num_d = cs_rdata;
      ST_DIV: begin
        // restoring division, one quotient bit a cycle
        if (dcnt_q == '0) begin
          rem_d = num_q + CSW'(nsq >> 1); quo_d = '0; dcnt_d = 5'd17;
        end else if (dcnt_q == 5'd1) begin
          dcnt_d = '0;
        end else begin
          dcnt_d = dcnt_q - 1'b1;
          if (rem_q >= (CSW'(nsq) << (dcnt_q - 5'd2))) begin
            rem_d = rem_q - (CSW'(nsq) << (dcnt_q - 5'd2));
            quo_d = {quo_q[SampleBits-2:0], 1'b1};
          end else quo_d = {quo_q[SampleBits-2:0], 1'b0};
        end
      end
      ST_OUT: begin
        rsp_d = '{mean: quo_q, last: frame_end, status: 1'b0};
        rv_d = 1'b1;
        if (frame_end) begin
          dpos_d = '0; lpos_d = '0;
          dx_d = '0; dy_d = '0; lx_d = '0; ly_d = '0;
        end else begin
          dpos_d = dpos_q + (AW+1)'(1);
          if (dx_end) begin
            dx_d = '0; dy_d = dy_q + 1'b1;
          end else dx_d = dx_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; lpos_q <= '0; dpos_q <= '0; rv_q <= 1'b0; dcnt_q <= '0;
      lx_q <= '0; ly_q <= '0; dx_q <= '0; dy_q <= '0;
    end else if (restart_i) begin
      st_q <= ST_IDLE; lpos_q <= '0; dpos_q <= '0; dcnt_q <= '0; rv_q <= rv_d;
      lx_q <= '0; ly_q <= '0; dx_q <= '0; dy_q <= '0;
    end else begin
      st_q <= st_d; lpos_q <= lpos_d; dpos_q <= dpos_d; rv_q <= rv_d;
      dcnt_q <= dcnt_d;
      lx_q <= lx_d; ly_q <= ly_d; dx_q <= dx_d; dy_q <= dy_d;
    end
  end
  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; m_q <= m_d; up_q <= up_d; cnt_q <= cnt_d;
    tcnt_q <= tcnt_d; acc_q <= acc_d; num_q <= num_d;
    quo_q <= quo_d; rem_q <= rem_d; rsp_q <= rsp_d; div_q <= nsq;
  end
  assign rsp_valid_o = rv_q;
  assign rsp_o = rsp_q;

`ifndef SYNTHESIS
  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !req_pop_o) else $error("pop while busy");
  a_lpos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lpos_q <= total || restart_i || $past(restart_i)) else $error("load overrun");
  a_div_const: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_DIV && dcnt_q > 5'd1 |-> div_q == nsq) else $error("divisor moved");
`endif
endmodule
